// ----- rtl/qxmm_pkg.sv -----
package qxmm_pkg;

  typedef struct packed {
    logic signed [15:0] roll_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_cmd;
    logic [14:0]        base_throttle;
    logic [15:0]        throttle_weight;
    logic               armed;
    logic               throttle_low;
  } mix_request_t;

  typedef struct packed {
    logic [14:0] motor_front_a;
    logic [14:0] motor_front_b;
    logic [14:0] motor_rear_a;
    logic [14:0] motor_rear_b;
  } mix_result_t;

  typedef enum logic [1:0] {
    REG_YAW_LIMIT  = 2'd0,
    REG_MOTOR_MAX  = 2'd1,
    REG_MOTOR_IDLE = 2'd2
  } cfg_reg_t;

  localparam int NUM_MOTORS = 4;
  localparam int LATENCY    = 7;

  localparam logic [9:0]  YAW_LIMIT_RST  = 10'd400;
  localparam logic [14:0] MOTOR_MAX_RST  = 15'd1000;
  localparam logic [14:0] MOTOR_IDLE_RST = 15'd200;

  localparam logic signed [17:0] MIX_LIMIT = 18'sd1000;

  // shaped*w/32768 = p*(385000 + 315*|p|)*w / (2^15 * 2^6 * 15625)
  localparam logic [19:0] SHAPE_BASE  = 20'd385000;
  localparam logic [19:0] SHAPE_SLOPE = 20'd315;

  // bias keeps the value positive before the unsigned divide
  localparam logic signed [32:0] QUOT_OFFSET = 33'sd1500000000;
  localparam logic [12:0]        QUOT_BIAS   = 13'd1500;

  localparam logic [26:0] DIV_D       = 27'd15625;
  localparam logic [26:0] RECIP_M     = 27'd70368744;
  localparam int          RECIP_SHIFT = 40;

endpackage

// ----- rtl/quad_x_motor_mixer_core.sv -----
// X-frame quad motor mixer. One request is taken in every clock cycle (busy stays low) and
// its four motor values appear on result with a one-cycle done strobe once they have passed
// the seven-register pipeline (mix and clamp, shaping factor, two multiplies, reciprocal
// divide, quotient correction, output clamp). There is no flow control on the result side:
// the receiver must take every done cycle. Registers (yaw_limit, motor_max, motor_idle) are
// written through the cfg channel, which is always ready, and must only change while no
// request is in flight.
module quad_x_motor_mixer_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  qxmm_pkg::mix_request_t  request,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [14:0]             cfg_data,
  output logic                    done,
  output qxmm_pkg::mix_result_t   result
);

  typedef struct packed {
    logic [14:0] thr;
    logic [15:0] w;
    logic        armed;
    logic        low;
  } side_t;

  localparam int NM = qxmm_pkg::NUM_MOTORS;

  logic [9:0]  yaw_limit;
  logic [14:0] motor_max;
  logic [14:0] motor_idle;

  logic [5:0] stage_valid;
  side_t      side [6];
  logic       out_valid;

  logic signed [10:0] s1_p     [NM];
  logic signed [10:0] s2_p     [NM];
  logic [19:0]        s2_f     [NM];
  logic signed [30:0] s3_prod  [NM];
  logic signed [47:0] s4_num   [NM];
  logic [52:0]        s5_vm    [NM];
  logic [25:0]        s5_v     [NM];
  logic signed [12:0] s6_q     [NM];
  logic [14:0]        motor    [NM];

  logic signed [10:0] p_next    [NM];
  logic [19:0]        f_next    [NM];
  logic signed [30:0] prod_next [NM];
  logic signed [47:0] num_next  [NM];
  logic [52:0]        vm_next   [NM];
  logic [25:0]        v_next    [NM];
  logic signed [12:0] q_next    [NM];
  logic [14:0]        motor_next[NM];

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign done      = out_valid;

  assign result.motor_front_a = motor[0];
  assign result.motor_front_b = motor[1];
  assign result.motor_rear_a  = motor[2];
  assign result.motor_rear_b  = motor[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_limit  <= qxmm_pkg::YAW_LIMIT_RST;
      motor_max  <= qxmm_pkg::MOTOR_MAX_RST;
      motor_idle <= qxmm_pkg::MOTOR_IDLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (qxmm_pkg::cfg_reg_t'(cfg_index))
        qxmm_pkg::REG_YAW_LIMIT:  yaw_limit  <= cfg_data[9:0];
        qxmm_pkg::REG_MOTOR_MAX:  motor_max  <= cfg_data;
        qxmm_pkg::REG_MOTOR_IDLE: motor_idle <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: yaw clamp, X mix, mix clamp
  logic signed [16:0] yl;
  logic signed [16:0] y_ext;
  logic signed [17:0] yc;
  logic signed [17:0] r18;
  logic signed [17:0] pt18;
  logic signed [17:0] mix [NM];

  always_comb begin
    yl    = signed'({7'b0, yaw_limit});
    y_ext = 17'(request.yaw_cmd);
    if (y_ext < -yl) begin
      yc = 18'(-yl);
    end else if (y_ext > yl) begin
      yc = 18'(yl);
    end else begin
      yc = 18'(y_ext);
    end
    r18  = 18'(request.roll_cmd);
    pt18 = 18'(request.pitch_cmd);
    mix[0] = -r18 - pt18 + yc;
    mix[1] = -r18 + pt18 - yc;
    mix[2] =  r18 + pt18 + yc;
    mix[3] =  r18 - pt18 - yc;
    for (int i = 0; i < NM; i++) begin
      if (mix[i] < -qxmm_pkg::MIX_LIMIT) begin
        p_next[i] = 11'(-qxmm_pkg::MIX_LIMIT);
      end else if (mix[i] > qxmm_pkg::MIX_LIMIT) begin
        p_next[i] = 11'(qxmm_pkg::MIX_LIMIT);
      end else begin
        p_next[i] = 11'(mix[i]);
      end
    end
  end

  // stages 2..6: shaping factor, p*f, *w, reciprocal divide, correction
  logic [9:0]  mag [NM];
  logic [32:0] x_u [NM];
  logic [12:0] q0  [NM];
  logic [26:0] rem [NM];
  logic [12:0] qc  [NM];

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      mag[i]       = s1_p[i] < 0 ? 10'(-s1_p[i]) : 10'(s1_p[i]);
      f_next[i]    = qxmm_pkg::SHAPE_BASE + 20'(mag[i]) * qxmm_pkg::SHAPE_SLOPE;
      prod_next[i] = 31'(32'(s2_p[i]) * 32'(signed'({1'b0, s2_f[i]})));
      num_next[i]  = 48'(s3_prod[i]) * 48'(signed'({1'b0, side[2].w}));
      x_u[i]       = 33'(s4_num[i][47:15]) + qxmm_pkg::QUOT_OFFSET;
      v_next[i]    = x_u[i][31:6];
      vm_next[i]   = 53'(v_next[i]) * 53'(qxmm_pkg::RECIP_M);
      q0[i]        = s5_vm[i][qxmm_pkg::RECIP_SHIFT +: 13];
      rem[i]       = 27'(s5_v[i]) - 27'(q0[i]) * qxmm_pkg::DIV_D;
      qc[i]        = q0[i] + 13'(rem[i] >= qxmm_pkg::DIV_D);
      q_next[i]    = signed'(qc[i] - qxmm_pkg::QUOT_BIAS);
    end
  end

  // output: throttle add, zero when disarmed, clamp to idle/max
  logic signed [16:0] total [NM];
  logic [14:0]        lo;

  always_comb begin
    lo = side[5].low ? 15'd0 : motor_idle;
    for (int i = 0; i < NM; i++) begin
      total[i] = signed'({2'b0, side[5].thr}) + 17'(s6_q[i]);
      if (!side[5].armed) begin
        motor_next[i] = '0;
      end else if (total[i] < signed'({2'b0, lo})) begin
        motor_next[i] = lo;
      end else if (total[i] > signed'({2'b0, motor_max})) begin
        motor_next[i] = motor_max;
      end else begin
        motor_next[i] = total[i][14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      stage_valid <= {stage_valid[4:0], accept};
      out_valid   <= stage_valid[5];
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= '{thr: request.base_throttle, w: request.throttle_weight,
                 armed: request.armed, low: request.throttle_low};
    for (int s = 1; s < 6; s++) begin
      side[s] <= side[s-1];
    end
    for (int i = 0; i < NM; i++) begin
      s1_p[i]    <= p_next[i];
      s2_p[i]    <= s1_p[i];
      s2_f[i]    <= f_next[i];
      s3_prod[i] <= prod_next[i];
      s4_num[i]  <= num_next[i];
      s5_vm[i]   <= vm_next[i];
      s5_v[i]    <= v_next[i];
      s6_q[i]    <= q_next[i];
      motor[i]   <= motor_next[i];
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(qxmm_pkg::LATENCY) done)
    else $error("request did not produce a result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, qxmm_pkg::LATENCY))
    else $error("result strobe without a matching request");

  a_disarmed_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(request.armed, qxmm_pkg::LATENCY)) |->
      (result.motor_front_a == '0 && result.motor_front_b == '0 &&
       result.motor_rear_a == '0 && result.motor_rear_b == '0))
    else $error("disarmed request gave nonzero motor output");

endmodule
